// ----- src/cht_pkg.sv -----
// Shared types and constants for the chained hash table.
// Request and response beat layouts, command and status codes.
// No dependencies.
package cht_pkg;

	// Key width and the split used by the bucket hash
	localparam int KEY_BITS = 31;
	localparam int LO_BITS  = 16;
	localparam int HI_BITS  = KEY_BITS - LO_BITS;

	// Width of the reported bucket number
	localparam int IDX_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef struct packed {
		cmd_t command;
		key_t key;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] bucket_index;
		key_t             match_key;
	} rsp_t;

endpackage

// ----- src/cht_stream_if.sv -----
// Valid/ready stream channel carrying one beat of a given payload type.
// Used for both the request and the response side of the hash table.
// No dependencies.
interface cht_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/chained_hash_table.sv -----
// Chained hash table: key store with one bounded chain per bucket.
// Depends on cht_pkg and cht_stream_if.
// Usage:
//   req  (sink)   : one beat per command, {command, key}, taken when valid and
//                  ready are both high at a rising edge of clk.
//   rsp  (source) : one beat per request, {status, bucket_index, match_key}.
//   The bucket is key modulo NUM_BUCKETS. An insert appends the key to its
//   bucket (duplicates allowed) or reports the bucket full; a search compares
//   the key with every filled slot of the bucket and reports found/not found.
// Sequence:
//   One request in flight at a time. The beat is taken in the idle state,
//   then the hash states (fold multiply, reciprocal multiply, raw remainder),
//   a state that corrects the remainder and reads the bucket row and fill
//   count, then the compare/write-back and response states. The response
//   becomes valid in the same cycle that req.ready rises again.
// Reset: arst_n clears the control state, then a sweep zeroes the fill count
//   of every bucket, one per cycle, with req.ready low.
//   Bucket slots are never cleared; only slots below the fill count are read.
// Stalls: the response sits in an output register until taken. A finished
//   request that finds that register still full waits there, and no new
//   request is taken until it has moved on.
module chained_hash_table #(
	parameter int NUM_BUCKETS  = 31,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	cht_stream_if.sink   req,
	cht_stream_if.source rsp
);
	import cht_pkg::*;

	// Bucket number, fill count and row geometry
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int ROW_W  = BUCKET_DEPTH * KEY_BITS;

	// Hash arithmetic: key = hi * 2^LO_BITS + lo, folded to
	// v = hi * (2^LO_BITS mod N) + lo, which keeps v below 2^V_W.
	// Then q ~= (v * floor(2^V_W / N)) >> V_W is at most one short,
	// so v - q*N lies below 2N and needs one correcting subtract.
	localparam int V_W = HI_BITS + BKT_W + 1;
	localparam int P_W = 2 * V_W;
	localparam int R_W = BKT_W + 1;
	localparam longint unsigned HASH_C = (64'd1 << LO_BITS) % NUM_BUCKETS;
	localparam longint unsigned HASH_M = (64'd1 << V_W) / NUM_BUCKETS;

	// Sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;  // sweep fill counts after reset
	localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a request beat
	localparam logic [2:0] S_FOLD  = 3'd2;  // fold the key
	localparam logic [2:0] S_RECIP = 3'd3;  // reciprocal multiply
	localparam logic [2:0] S_REM   = 3'd4;  // raw remainder
	localparam logic [2:0] S_READ  = 3'd5;  // correct remainder, read bucket
	localparam logic [2:0] S_CMP   = 3'd6;  // compare slots, write back
	localparam logic [2:0] S_RESP  = 3'd7;  // build and hand over response

	logic [2:0]       state_q;
	logic [BKT_W-1:0] clr_q;

	// Request held for the whole operation
	cmd_t             cmd_q;
	key_t             key_q;

	// Hash datapath
	logic [V_W-1:0]   v_q;
	logic [V_W-1:0]   qe_q;
	logic [R_W-1:0]   rem_q;
	logic [BKT_W-1:0] bucket_q;
	logic [V_W-1:0]   v_d;
	logic [P_W-1:0]   recip_prod;
	logic [V_W-1:0]   rem_full;
	logic [BKT_W-1:0] bucket_d;

	// Memories: one row of slots per bucket, and one fill count per bucket
	logic [ROW_W-1:0]  entry_mem [NUM_BUCKETS];
	logic [FILL_W-1:0] fill_mem  [NUM_BUCKETS];
	logic [ROW_W-1:0]  row_rd_q;
	logic [FILL_W-1:0] fill_rd_q;

	// Compare and update
	logic [BUCKET_DEPTH-1:0] hit_vec;
	logic [BUCKET_DEPTH-1:0] hit_vec_q;
	logic [ROW_W-1:0]        row_new;
	logic                    full_d;
	logic                    full_q;
	logic                    row_we;
	logic                    fill_we;
	logic [BKT_W-1:0]        fill_waddr;
	logic [FILL_W-1:0]       fill_wdata;

	// Response
	rsp_t rsp_d;
	rsp_t out_q;
	logic out_valid_q;
	logic out_free;
	logic out_load;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// ------------------------------------------------------------------
	// Hash: key modulo NUM_BUCKETS over the fold, reciprocal multiply, remainder and correction cycles
	// ------------------------------------------------------------------
	assign v_d = V_W'(key_q[KEY_BITS-1:LO_BITS]) * V_W'(HASH_C)
			+ V_W'(key_q[LO_BITS-1:0]);

	assign recip_prod = P_W'(v_q) * P_W'(HASH_M);

	assign rem_full = v_q - qe_q * V_W'(NUM_BUCKETS);

	// Remainder is below 2N: one correcting subtract
	assign bucket_d = (rem_q >= R_W'(NUM_BUCKETS))
			? BKT_W'(rem_q - R_W'(NUM_BUCKETS))
			: BKT_W'(rem_q);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.data.command;
			key_q <= req.data.key;
		end
		if (state_q == S_FOLD) begin
			v_q <= v_d;
		end
		if (state_q == S_RECIP) begin
			qe_q <= recip_prod[P_W-1:V_W];
		end
		if (state_q == S_REM) begin
			rem_q <= R_W'(rem_full);
		end
		if (state_q == S_READ) begin
			bucket_q <= bucket_d;
		end
	end

	// ------------------------------------------------------------------
	// Memory reads: issued in S_READ, data back in S_CMP
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			row_rd_q  <= entry_mem[bucket_d];
			fill_rd_q <= fill_mem[bucket_d];
		end
	end

	// ------------------------------------------------------------------
	// Compare every filled slot; build the row with the new key appended
	// ------------------------------------------------------------------
	for (genvar i = 0; i < BUCKET_DEPTH; i++) begin : g_slot
		assign hit_vec[i] = (FILL_W'(i) < fill_rd_q)
				&& (row_rd_q[i*KEY_BITS +: KEY_BITS] == key_q);
		assign row_new[i*KEY_BITS +: KEY_BITS] = (fill_rd_q == FILL_W'(i))
				? key_q : row_rd_q[i*KEY_BITS +: KEY_BITS];
	end

	assign full_d = (fill_rd_q >= FILL_W'(BUCKET_DEPTH));

	assign row_we = (state_q == S_CMP) && (cmd_q == CMD_INSERT) && !full_d;

	// Fill port is shared by the reset sweep and the insert update
	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = fill_rd_q + FILL_W'(1);
		if (state_q == S_CLEAR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
			fill_wdata = '0;
		end else if (row_we) begin
			fill_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			entry_mem[bucket_q] <= row_new;
		end
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			hit_vec_q <= hit_vec;
			full_q    <= full_d;
		end
	end

	// ------------------------------------------------------------------
	// Response: reduce the hit vector and hand over when the register frees
	// ------------------------------------------------------------------
	always_comb begin
		rsp_d.bucket_index = IDX_W'(bucket_q);
		rsp_d.match_key    = '0;
		if (cmd_q == CMD_INSERT) begin
			rsp_d.status = full_q ? ST_FULL : ST_INSERTED;
		end else if (|hit_vec_q) begin
			rsp_d.status    = ST_FOUND;
			rsp_d.match_key = key_q;
		end else begin
			rsp_d.status = ST_MISSING;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = (state_q == S_RESP) && out_free;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					// Advance the sweep; leave once the last bucket is zeroed
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD:  state_q <= S_RECIP;
				S_RECIP: state_q <= S_REM;
				S_REM:   state_q <= S_READ;
				S_READ:  state_q <= S_CMP;
				S_CMP:   state_q <= S_RESP;
				S_RESP: begin
					// Hold until the output register can take the beat
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the chained hash table: directed and random insert/search traffic.
// Predicts every response from its own bucket model and checks it against the rsp channel.
// Depends on cht_pkg, cht_stream_if and chained_hash_table.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cht_pkg::*;

	localparam int N_BUCKETS   = 31;
	localparam int CHAIN_DEPTH = 8;
	// Request beat to response beat; pads the final wait before the verdict
	localparam int RSP_LATENCY = 6;
	// Quiet cycles tolerated before the run is declared hung. The longest quiet
	// stretch in a correct run is the deliberate receiver hold-off, well below
	// this limit.
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam key_t KEY_MAX   = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cht_stream_if #(.data_t(req_t)) req_if ();
	cht_stream_if #(.data_t(rsp_t)) rsp_if ();

	chained_hash_table #(
		.NUM_BUCKETS (N_BUCKETS),
		.BUCKET_DEPTH(CHAIN_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Shadow copy of the table: the keys of each chain and how many are filled.
	// Slots at or above the fill count are never looked at.
	key_t        chain_key [N_BUCKETS][CHAIN_DEPTH];
	int unsigned chain_len [N_BUCKETS];

	// Responses still owed by the block, oldest first
	rsp_t expected_rsp [$];
	// Keys that made it into the table; reused to hit in searches and to duplicate
	key_t stored_keys [$];

	int unsigned error_count   = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	// Bumped by a test to ask the receiver for one long hold-off
	int unsigned hold_seq      = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the response to one command and advance the shadow table.
	// A full chain refuses the insert and leaves the table untouched; a
	// search reports one hit however many equal keys the chain holds.
	function automatic rsp_t predict_lookup(cmd_t cmd, key_t key);
		rsp_t        r;
		logic [31:0] b;
		b              = key % N_BUCKETS;
		r.status       = ST_MISSING;
		r.bucket_index = b[IDX_W-1:0];
		r.match_key    = '0;
		if (cmd == CMD_INSERT) begin
			if (chain_len[b] >= CHAIN_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				chain_key[b][chain_len[b]] = key;
				chain_len[b]++;
				r.status = ST_INSERTED;
				stored_keys.push_back(key);
			end
		end else begin
			for (int i = 0; i < chain_len[b]; i++) begin
				if (chain_key[b][i] == key) begin
					r.status    = ST_FOUND;
					r.match_key = key;
				end
			end
		end
		return r;
	endfunction

	// Offer one request beat and hold it until taken. Entered and left at a
	// rising edge; valid stays high on exit so back-to-back beats never see
	// valid dropped and raised in the same step.
	task automatic send_command(cmd_t cmd, key_t key);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.data  <= req_t'($urandom);
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= '{command: cmd, key: key};
		do @(posedge clk); while (!req_if.ready);
		expected_rsp.push_back(predict_lookup(cmd, key));
	endtask

	// Drop valid and hold the sender until every owed response has come back
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (expected_rsp.size() != 0);
	endtask

	// One random command. Most keys are either already stored (hits and
	// duplicates) or aimed at a random bucket so chains fill up and overflow;
	// the rest are the field extremes or any key at all, which mostly miss.
	task automatic random_command();
		cmd_t            cmd;
		key_t            key;
		int unsigned     pick;
		int unsigned     b;
		longint unsigned span;
		cmd  = $urandom_range(1) ? CMD_SEARCH : CMD_INSERT;
		pick = $urandom_range(99);
		if (pick < 35 && stored_keys.size() != 0) begin
			key = stored_keys[$urandom_range(stored_keys.size() - 1)];
		end else if (pick < 65) begin
			b    = $urandom_range(N_BUCKETS - 1);
			span = (longint'(KEY_MAX) - b) / N_BUCKETS;
			key  = key_t'(b + longint'(N_BUCKETS) * $urandom_range(span, 0));
		end else if (pick < 70) begin
			key = $urandom_range(1) ? KEY_MAX : key_t'(0);
		end else begin
			key = key_t'($urandom);
		end
		send_command(cmd, key);
	endtask

	// Empty table, key zero and the largest key, and the top bucket number
	task automatic test_empty_and_extremes();
		send_command(CMD_SEARCH, key_t'(0));              // miss on an empty table
		send_command(CMD_INSERT, key_t'(0));
		send_command(CMD_SEARCH, key_t'(0));              // found, yet match_key is zero
		send_command(CMD_INSERT, KEY_MAX);
		send_command(CMD_SEARCH, KEY_MAX);
		send_command(CMD_SEARCH, key_t'(1));              // same bucket as KEY_MAX, absent
		send_command(CMD_INSERT, key_t'(N_BUCKETS - 1));  // highest bucket number
		send_command(CMD_SEARCH, key_t'(N_BUCKETS - 1));
		send_command(CMD_SEARCH, key_t'(2 * N_BUCKETS - 1));
		wait_for_results();
	endtask

	// Fill one chain to the brim, including a duplicate, then overflow it
	task automatic test_full_bucket();
		localparam int B = 7;
		for (int k = 0; k < CHAIN_DEPTH - 1; k++)
			send_command(CMD_INSERT, key_t'(B + N_BUCKETS * k));
		send_command(CMD_INSERT, key_t'(B));                   // duplicate takes the last slot
		send_command(CMD_INSERT, key_t'(B + N_BUCKETS * 100)); // refused, chain full
		send_command(CMD_SEARCH, key_t'(B));                   // two copies, one hit
		send_command(CMD_SEARCH, key_t'(B + N_BUCKETS * 100)); // the refused key is absent
		wait_for_results();
	endtask

	// Hold the response side off for a long stretch while requests keep
	// coming, so the output register and the request in flight back up and
	// req.ready stays low; then pause the sender until everything drains.
	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		hold_seq      <= hold_seq + 1;
		repeat (8) random_command();
		wait_for_results();
	endtask

	task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
			int unsigned stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		repeat (n) random_command();
	endtask

	// Response-side ready: random stalls at the current rate, or a long
	// hold-off counted here whenever a test asks for one
	initial begin : drive_rsp_ready
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left    = 0;
		hold_seen    = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Compare each response beat, field by field, with the oldest prediction
	always @(posedge clk) begin : check_rsp
		rsp_t wanted;
		rsp_t got;
		if (rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (expected_rsp.size() == 0) begin
				$error("response beat with nothing outstanding: status %0d bucket %0d key %0d",
					got.status, got.bucket_index, got.match_key);
				error_count++;
			end else begin
				wanted = expected_rsp.pop_front();
				if (got.status !== wanted.status) begin
					$error("status: expected %0d, got %0d", wanted.status, got.status);
					error_count++;
				end
				if (got.bucket_index !== wanted.bucket_index) begin
					$error("bucket_index: expected %0d, got %0d",
						wanted.bucket_index, got.bucket_index);
					error_count++;
				end
				if (got.match_key !== wanted.match_key) begin
					$error("match_key: expected %0d, got %0d", wanted.match_key, got.match_key);
					error_count++;
				end
			end
		end
	end

	// Hang detection: count cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run_tests
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The block sweeps its fill counts after reset with req.ready low;
		// the first beat simply waits for it.
		test_empty_and_extremes();
		test_full_bucket();
		test_backpressure();
		test_random_traffic(355, 0, 0);
		test_random_traffic(355, 80, 0);
		test_random_traffic(355, 0, 80);
		test_random_traffic(355, 28, 28);

		wait_for_results();
		repeat (RSP_LATENCY + 5) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
